FILE: sv/assert_macros.svh
// Assertion macros used by the checker file of this block, gelu_chk.sv.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion with a generic failure report.
`define CHK_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("%m: check failed");

// Concurrent assertion with a caller-supplied failure report.
`define CHK_ASSERT_MSG(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

`endif

FILE: sv/gelu_pkg.sv
// Constants, types and helper functions for the GELU activation pipeline.
// No dependencies; used by every module of the block except gelu_chk.
package gelu_pkg;

	localparam int HORNER_TERMS = 7;
	localparam int HRN_STAGES   = 2 * HORNER_TERMS;
	localparam int QUO_W        = 31;

	localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
	localparam logic [19:0] COEFF_Q24 = 20'd750193;
	localparam logic [23:0] K_Q24     = 24'd13386282;
	localparam logic [23:0] LN2_Q24   = 24'd11629080;
	localparam logic [27:0] ZMAX_Q24  = 28'd134217728;

	typedef struct packed {
		logic        neg;
		logic [16:0] mag;
		logic        last;
	} side_t;

	// ceil(2^33 / k): exact floor division by k for any 30-bit dividend.
	function automatic logic [33:0] recip_k(input logic [2:0] k);
		logic [33:0] r;
		case (k)
			3'd1:    r = 34'd8589934592;
			3'd2:    r = 34'd4294967296;
			3'd3:    r = 34'd2863311531;
			3'd4:    r = 34'd2147483648;
			3'd5:    r = 34'd1717986919;
			3'd6:    r = 34'd1431655766;
			3'd7:    r = 34'd1227133514;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

FILE: sv/gelu_exp.sv
// Range reduction by ln2 and a Horner evaluation of exp(-r), giving the
// divisor 1 + exp(-2z) in Q.30. Depends on gelu_pkg.
module gelu_exp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  src_vld,
	input  logic [28:0]           w,
	input  gelu_pkg::side_t       src_side,
	output logic                  res_vld,
	output logic [31:0]           dvs,
	output gelu_pkg::side_t       res_side
);
	import gelu_pkg::*;

	logic [28:0] rem_a;
	logic [2:0]  nhi_a;
	logic        vld_s1;
	logic [25:0] rem_s1;
	logic [2:0]  nhi_s1;
	side_t       side_s1;

	logic [25:0] rem_b;
	logic [1:0]  nlo_b;
	logic        vld_s2;
	logic [29:0] r_s2;
	logic [4:0]  n_s2;
	side_t       side_s2;

	logic        hrn_vld_s  [HRN_STAGES];
	logic [29:0] hrn_val_s  [HRN_STAGES];
	logic [29:0] hrn_r_s    [HRN_STAGES];
	logic [4:0]  hrn_n_s    [HRN_STAGES];
	side_t       hrn_side_s [HRN_STAGES];

	logic [30:0] acc_e;
	logic [30:0] exp_e;
	logic        vld_s3;
	logic [31:0] dvs_s3;
	side_t       side_s3;

	always_comb begin
		rem_a = w;
		for (int b = 4; b >= 2; b--) begin
			if (rem_a >= (29'(LN2_Q24) << b)) begin
				rem_a      = rem_a - (29'(LN2_Q24) << b);
				nhi_a[b-2] = 1'b1;
			end else begin
				nhi_a[b-2] = 1'b0;
			end
		end
	end

	always_comb begin
		rem_b = rem_s1;
		for (int b = 1; b >= 0; b--) begin
			if (rem_b >= (26'(LN2_Q24) << b)) begin
				rem_b    = rem_b - (26'(LN2_Q24) << b);
				nlo_b[b] = 1'b1;
			end else begin
				nlo_b[b] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= src_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1  <= rem_a[25:0];
			nhi_s1  <= nhi_a;
			side_s1 <= src_side;
			r_s2    <= {rem_b[23:0], 6'b0};
			n_s2    <= {nhi_s1, nlo_b};
			side_s2 <= side_s1;
		end
	end

	for (genvar i = 0; i < HRN_STAGES; i++) begin : g_hrn
		localparam logic [2:0] KDIV = 3'(HORNER_TERMS - i / 2);
		logic        vld_in;
		logic [29:0] r_in;
		logic [4:0]  n_in;
		side_t       side_in;
		logic [29:0] val_d;

		if (i == 0) begin : g_first
			assign vld_in  = vld_s2;
			assign r_in    = r_s2;
			assign n_in    = n_s2;
			assign side_in = side_s2;
		end else begin : g_next
			assign vld_in  = hrn_vld_s[i-1];
			assign r_in    = hrn_r_s[i-1];
			assign n_in    = hrn_n_s[i-1];
			assign side_in = hrn_side_s[i-1];
		end

		if (i % 2 == 0) begin : g_mul
			logic [30:0] acc;
			logic [60:0] prod;
			if (i == 0) begin : g_one
				assign acc = ONE_Q30;
			end else begin : g_sub
				assign acc = ONE_Q30 - {1'b0, hrn_val_s[i-1]};
			end
			assign prod  = 61'(r_in) * 61'(acc);
			assign val_d = prod[59:30];
		end else begin : g_div
			logic [63:0] prod;
			assign prod  = 64'(hrn_val_s[i-1]) * 64'(recip_k(KDIV));
			assign val_d = prod[62:33];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				hrn_vld_s[i] <= 1'b0;
			end else if (en) begin
				hrn_vld_s[i] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				hrn_val_s[i]  <= val_d;
				hrn_r_s[i]    <= r_in;
				hrn_n_s[i]    <= n_in;
				hrn_side_s[i] <= side_in;
			end
		end
	end

	assign acc_e = ONE_Q30 - {1'b0, hrn_val_s[HRN_STAGES-1]};
	assign exp_e = acc_e >> hrn_n_s[HRN_STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= hrn_vld_s[HRN_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dvs_s3  <= {1'b0, ONE_Q30} + {1'b0, exp_e};
			side_s3 <= hrn_side_s[HRN_STAGES-1];
		end
	end

	assign res_vld  = vld_s3;
	assign dvs      = dvs_s3;
	assign res_side = side_s3;

endmodule

FILE: sv/gelu_div.sv
// Pipelined restoring divider computing floor(2^60 / dvs), one quotient bit
// per stage, which is the logistic term in Q.30. Depends on gelu_pkg.
module gelu_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        src_vld,
	input  logic [31:0]                 dvs,
	input  gelu_pkg::side_t             src_side,
	output logic                        res_vld,
	output logic [gelu_pkg::QUO_W-1:0]  quo,
	output gelu_pkg::side_t             res_side
);
	import gelu_pkg::*;

	localparam logic [31:0] REM_INIT = 32'(ONE_Q30) >> 1;

	logic             vld_s  [QUO_W];
	side_t            side_s [QUO_W];
	logic [31:0]      dvs_s  [QUO_W];
	logic [31:0]      rem_s  [QUO_W];
	logic [QUO_W-1:0] quo_s  [QUO_W];

	for (genvar i = 0; i < QUO_W; i++) begin : g_bit
		logic             vld_in;
		side_t            side_in;
		logic [31:0]      dvs_in;
		logic [31:0]      rem_in;
		logic [QUO_W-1:0] quo_in;
		logic [32:0]      shf;
		logic [32:0]      dif;
		logic             ge;
		logic [31:0]      rem_d;
		logic [QUO_W-1:0] quo_d;

		if (i == 0) begin : g_first
			assign vld_in  = src_vld;
			assign side_in = src_side;
			assign dvs_in  = dvs;
			assign rem_in  = REM_INIT;
			assign quo_in  = '0;
		end else begin : g_next
			assign vld_in  = vld_s[i-1];
			assign side_in = side_s[i-1];
			assign dvs_in  = dvs_s[i-1];
			assign rem_in  = rem_s[i-1];
			assign quo_in  = quo_s[i-1];
		end

		assign shf   = {rem_in, 1'b0};
		assign dif   = shf - {1'b0, dvs_in};
		assign ge    = shf >= {1'b0, dvs_in};
		assign rem_d = ge ? dif[31:0] : shf[31:0];

		always_comb begin
			quo_d              = quo_in;
			quo_d[QUO_W-1-i]   = ge;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[i] <= side_in;
				dvs_s[i]  <= dvs_in;
				rem_s[i]  <= rem_d;
				quo_s[i]  <= quo_d;
			end
		end
	end

	assign res_vld  = vld_s[QUO_W-1];
	assign quo      = quo_s[QUO_W-1];
	assign res_side = side_s[QUO_W-1];

endmodule

FILE: sv/gelu_tanh_activation.sv
// GELU activation, tanh form, on signed Q3.12 samples, using gelu_exp and gelu_div.
// Depends on gelu_pkg.
//
// Each accepted item yields one activation, with is_last copied to
// last_out, and a new item is taken every cycle while activation_ready
// is high. The pipeline depth is set mostly by the 31-stage reciprocal
// divider and the seven-term Horner chain for the exponential, each step of
// which takes a multiply stage and a divide-by-constant stage. A skid register
// behind the output register lets one further item in while a result waits;
// sample_ready then drops until the output drains and the whole pipeline holds.
module gelu_tanh_activation (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [15:0] sample,
	input  logic               is_last,
	input  logic               sample_valid,
	output logic               sample_ready,
	output logic signed [15:0] activation,
	output logic               last_out,
	output logic               activation_valid,
	input  logic               activation_ready
);
	import gelu_pkg::*;

	logic        en;
	side_t       side_in;

	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	side_t       side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7, side_s8;
	logic [30:0] sq_s2;
	logic [45:0] cub_s3;
	logic [28:0] ctm_s4;
	logic [29:0] u_s5;
	logic [29:0] z_s6;
	logic [28:0] w_s7;
	logic [47:0] prod_s8;

	logic [33:0] sq_full;
	logic [47:0] cub_full;
	logic [53:0] ctm_full;
	logic [53:0] z_full;
	logic [27:0] z_sat;

	logic        exp_vld;
	logic [31:0] exp_dvs;
	side_t       exp_side;
	logic        div_vld;
	logic [QUO_W-1:0] div_quo;
	side_t       div_side;
	logic [30:0] sig;

	logic [48:0]        rnd;
	logic [17:0]        mag;
	logic signed [18:0] yw;
	logic [15:0]        y;

	logic        out_vld_q, skid_vld_q;
	logic [15:0] act_q, skid_act_q;
	logic        last_q, skid_last_q;

	assign en           = !skid_vld_q;
	assign sample_ready = en;

	assign side_in.neg  = sample[15];
	assign side_in.mag  = sample[15] ? (17'h10000 - {1'b0, sample}) : {1'b0, sample};
	assign side_in.last = is_last;

	assign sq_full  = 34'(side_s1.mag) * 34'(side_s1.mag);
	assign cub_full = 48'(sq_s2) * 48'(side_s2.mag);
	assign ctm_full = 54'(cub_s3[45:12]) * 54'(COEFF_Q24);
	assign z_full   = 54'(u_s5) * 54'(K_Q24);
	assign z_sat    = (z_s6 > 30'(ZMAX_Q24)) ? ZMAX_Q24 : z_s6[27:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s1 <= sample_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_in;
			side_s2 <= side_s1;
			sq_s2   <= sq_full[30:0];
			side_s3 <= side_s2;
			cub_s3  <= cub_full[45:0];
			side_s4 <= side_s3;
			ctm_s4  <= ctm_full[52:24];
			side_s5 <= side_s4;
			u_s5    <= 30'({side_s4.mag, 12'b0}) + 30'(ctm_s4);
			side_s6 <= side_s5;
			z_s6    <= z_full[53:24];
			side_s7 <= side_s6;
			w_s7    <= {z_sat, 1'b0};
			side_s8 <= div_side;
			prod_s8 <= 48'(div_side.mag) * 48'(sig);
		end
	end

	gelu_exp u_exp (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.src_vld  (vld_s7),
		.w        (w_s7),
		.src_side (side_s7),
		.res_vld  (exp_vld),
		.dvs      (exp_dvs),
		.res_side (exp_side)
	);

	gelu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.src_vld  (exp_vld),
		.dvs      (exp_dvs),
		.src_side (exp_side),
		.res_vld  (div_vld),
		.quo      (div_quo),
		.res_side (div_side)
	);

	assign sig = div_side.neg ? (ONE_Q30 - div_quo) : div_quo;

	assign rnd = 49'(prod_s8) + 49'(ONE_Q30 >> 1);
	assign mag = rnd[47:30];
	assign yw  = side_s8.neg ? (19'sd0 - $signed({1'b0, mag})) : $signed({1'b0, mag});

	always_comb begin
		if (yw > 19'sd32767) begin
			y = 16'h7FFF;
		end else if (yw < -19'sd32768) begin
			y = 16'h8000;
		end else begin
			y = yw[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (activation_ready) begin
				skid_vld_q <= 1'b0;
			end
		end else if (vld_s8) begin
			if (!out_vld_q || activation_ready) begin
				out_vld_q <= 1'b1;
			end else begin
				skid_vld_q <= 1'b1;
			end
		end else if (activation_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (activation_ready) begin
				act_q  <= skid_act_q;
				last_q <= skid_last_q;
			end
		end else if (vld_s8) begin
			if (!out_vld_q || activation_ready) begin
				act_q  <= y;
				last_q <= side_s8.last;
			end else begin
				skid_act_q  <= y;
				skid_last_q <= side_s8.last;
			end
		end
	end

	assign activation       = $signed(act_q);
	assign last_out         = last_q;
	assign activation_valid = out_vld_q;

endmodule

FILE: sv/gelu_chk.sv
// Port-level checker for gelu_tanh_activation, attached by the bind below.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module gelu_chk (
	input logic               clk,
	input logic               arst_n,
	input logic signed [15:0] sample,
	input logic               is_last,
	input logic               sample_valid,
	input logic               sample_ready,
	input logic signed [15:0] activation,
	input logic               last_out,
	input logic               activation_valid,
	input logic               activation_ready
);

	`CHK_ASSERT(a_out_hold, activation_valid && !activation_ready |=> activation_valid)
	`CHK_ASSERT(a_out_stable, activation_valid && !activation_ready |=> $stable({activation, last_out}))
	`CHK_ASSERT_MSG(a_ready_low, !sample_ready |-> activation_valid, "input blocked, nothing waiting")
	`CHK_ASSERT_MSG(a_gelu_floor, activation_valid |-> activation >= -16'sd720, "below GELU minimum")

endmodule

bind gelu_tanh_activation gelu_chk u_gelu_chk (.*);

FILE: tb/tb_top.sv
// Self-checking testbench for gelu_tanh_activation: a directed table of samples, then
// random samples, with random idling on both handshakes and one long output stall.
// Depends on gelu_pkg for the fixed-point constants used by the GELU predictor.
module tb_top;

	import gelu_pkg::*;

	localparam int RANDOM_ITEMS = 1900;
	localparam int STALL_AFTER  = 300;
	localparam int STALL_CYCLES = 400;
	localparam int IDLE_LIMIT   = 3000;
	localparam int DRAIN_CYCLES = 80;

	typedef struct packed {
		logic signed [15:0] act;
		logic               last;
	} gelu_res_t;

	typedef struct packed {
		logic [15:0] x;
		logic        last;
		logic        typed;
		logic [15:0] y;
	} table_row_t;

	localparam int N_ROWS = 24;
	localparam table_row_t SAMPLE_TABLE [N_ROWS] = '{
		'{16'h0000, 1'b0, 1'b1, 16'h0000},
		'{16'h0000, 1'b1, 1'b1, 16'h0000},
		'{16'h7FFF, 1'b0, 1'b1, 16'h7FFF},
		'{16'h8000, 1'b1, 1'b1, 16'h0000},
		'{16'h0001, 1'b0, 1'b0, 16'h0000},
		'{16'hFFFF, 1'b1, 1'b0, 16'h0000},
		'{16'h1000, 1'b0, 1'b0, 16'h0000},
		'{16'hF000, 1'b0, 1'b0, 16'h0000},
		'{16'h2000, 1'b1, 1'b0, 16'h0000},
		'{16'hE000, 1'b0, 1'b0, 16'h0000},
		'{16'h3000, 1'b0, 1'b0, 16'h0000},
		'{16'hD000, 1'b1, 1'b0, 16'h0000},
		'{16'h38CC, 1'b0, 1'b0, 16'h0000},
		'{16'hC734, 1'b0, 1'b0, 16'h0000},
		'{16'h3800, 1'b0, 1'b0, 16'h0000},
		'{16'h3900, 1'b1, 1'b0, 16'h0000},
		'{16'h4000, 1'b0, 1'b0, 16'h0000},
		'{16'hC000, 1'b0, 1'b0, 16'h0000},
		'{16'h5555, 1'b0, 1'b0, 16'h0000},
		'{16'hAAAA, 1'b1, 1'b0, 16'h0000},
		'{16'h7000, 1'b0, 1'b0, 16'h0000},
		'{16'h9000, 1'b0, 1'b0, 16'h0000},
		'{16'h0800, 1'b0, 1'b0, 16'h0000},
		'{16'hF800, 1'b1, 1'b0, 16'h0000}
	};

	logic               clk;
	logic               arst_n;
	logic signed [15:0] sample;
	logic               is_last;
	logic               sample_valid;
	logic               sample_ready;
	logic signed [15:0] activation;
	logic               last_out;
	logic               activation_valid;
	logic               activation_ready;

	logic      typed_hold;
	gelu_res_t typed_res;

	gelu_res_t pending_gelu [$];
	int        fault_count;
	int        stray_count;
	int        checked_count;
	int        sent_count;

	gelu_tanh_activation uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.sample           (sample),
		.is_last          (is_last),
		.sample_valid     (sample_valid),
		.sample_ready     (sample_ready),
		.activation       (activation),
		.last_out         (last_out),
		.activation_valid (activation_valid),
		.activation_ready (activation_ready)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic signed [15:0] gelu_expected(input logic [15:0] raw);
		logic              neg;
		longint unsigned   one, m, m3, cube, u, z, w, n, r, acc, e, sp, s, mag;
		longint unsigned   k;
		longint            y;
		one  = longint'(ONE_Q30);
		neg  = raw[15];
		m    = neg ? (64'h10000 - {48'd0, raw}) : {48'd0, raw};
		m3   = m * m * m;
		cube = ((m3 >> 12) * longint'(COEFF_Q24)) >> 24;
		u    = (m << 12) + cube;
		z    = (u * longint'(K_Q24)) >> 24;
		if (z > longint'(ZMAX_Q24))
			z = longint'(ZMAX_Q24);
		w   = z * 2;
		n   = w / longint'(LN2_Q24);
		r   = (w - n * longint'(LN2_Q24)) << 6;
		acc = one;
		for (k = 7; k >= 1; k--)
			acc = one - ((r * acc) >> 30) / k;
		e   = (n < 63) ? (acc >> n) : 64'd0;
		sp  = (64'd1 << 60) / (one + e);
		s   = neg ? (one - sp) : sp;
		mag = (m * s + (64'd1 << 29)) >> 30;
		y   = neg ? -longint'(mag) : longint'(mag);
		if (y > 32767)
			y = 32767;
		if (y < -32768)
			y = -32768;
		return y[15:0];
	endfunction

	function automatic logic [15:0] random_sample();
		int          kind;
		logic [15:0] v;
		kind = $urandom_range(0, 9);
		if (kind <= 3) begin
			v = 16'($signed($urandom_range(0, 32768)) - 16384);
		end else if (kind <= 5) begin
			v = 16'($urandom_range(13000, 16000));
			if ($urandom_range(0, 1))
				v = -v;
		end else if (kind <= 8) begin
			v = 16'($urandom);
		end else begin
			case ($urandom_range(0, 4))
				0:       v = 16'h7FF0 | 16'($urandom_range(0, 15));
				1:       v = 16'h8000 | 16'($urandom_range(0, 15));
				2:       v = 16'h0000;
				3:       v = 16'h0001;
				default: v = 16'hFFFF;
			endcase
		end
		return v;
	endfunction

	// Called at a rising edge; returns at the edge on which the item is taken.
	task automatic offer_sample(input logic [15:0] x, input logic last, input logic typed,
	                            input logic [15:0] y, input int gap);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample       <= x;
		is_last      <= last;
		typed_hold   <= typed;
		typed_res    <= '{act: y, last: last};
		sample_valid <= 1'b1;
		@(posedge clk);
		while (!sample_ready)
			@(posedge clk);
		sent_count++;
	endtask

	always @(posedge clk) begin
		gelu_res_t want;
		if (arst_n) begin
			if (sample_valid && sample_ready)
				pending_gelu.push_back(typed_hold ? typed_res
					: gelu_res_t'{act: gelu_expected(sample), last: is_last});
			if (activation_valid && activation_ready) begin
				if (pending_gelu.size() == 0) begin
					stray_count++;
					fault_count++;
					if (fault_count <= 10)
						$display("unexpected item: activation=%0d last_out=%0b",
							activation, last_out);
				end else begin
					want = pending_gelu.pop_front();
					checked_count++;
					if (activation !== want.act || last_out !== want.last) begin
						fault_count++;
						if (fault_count <= 10)
							$display("mismatch on item %0d: expected %0d/%0b, got %0d/%0b",
								checked_count, want.act, want.last, activation, last_out);
					end
				end
			end
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((sample_valid && sample_ready) || (activation_valid && activation_ready))
				idle = 0;
			else
				idle++;
		end
		$display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
		$display("gelu_tanh_activation regression: fail");
		$finish;
	end

	initial begin
		int  taken;
		int  w;
		bit  burst;
		bit  stalled;
		activation_ready = 1'b0;
		taken   = 0;
		burst   = 1'b0;
		stalled = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (taken % 64 == 0)
				burst = ($urandom_range(0, 3) == 0);
			w = burst ? 0 : $urandom_range(0, 6);
			if (!stalled && taken == STALL_AFTER) begin
				w       = STALL_CYCLES;
				stalled = 1'b1;
			end
			if (w > 0) begin
				activation_ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			activation_ready <= 1'b1;
			@(posedge clk);
			while (!activation_valid)
				@(posedge clk);
			taken++;
		end
	end

	initial begin
		int  i;
		int  gap;
		bit  burst;
		bit  leftover;
		arst_n        = 1'b0;
		sample        = '0;
		is_last       = 1'b0;
		sample_valid  = 1'b0;
		typed_hold    = 1'b0;
		typed_res     = '0;
		fault_count   = 0;
		stray_count   = 0;
		checked_count = 0;
		sent_count    = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < N_ROWS; i++)
			offer_sample(SAMPLE_TABLE[i].x, SAMPLE_TABLE[i].last, SAMPLE_TABLE[i].typed,
				SAMPLE_TABLE[i].y, $urandom_range(0, 6));

		burst = 1'b0;
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 64 == 0)
				burst = ($urandom_range(0, 3) == 0);
			gap = burst ? 0 : $urandom_range(0, 6);
			offer_sample(random_sample(), ($urandom_range(0, 15) == 0), 1'b0, 16'h0000, gap);
		end
		sample_valid <= 1'b0;

		while (pending_gelu.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		leftover = (pending_gelu.size() != 0);

		$display("Fed %0d samples (directed table and random mix), compared %0d activations,",
			sent_count, checked_count);
		$display("with random idling on both sides and one %0d-cycle output stall.",
			STALL_CYCLES);
		if (fault_count == 0 && stray_count == 0 && !leftover) begin
			$display("gelu_tanh_activation regression: pass");
		end else begin
			$display("%0d faults, %0d unexpected items, %0d items outstanding",
				fault_count, stray_count, pending_gelu.size());
			$display("gelu_tanh_activation regression: fail");
		end
		$finish;
	end

endmodule
